>>> rtl/core/fud_pkg.sv
`timescale 1ns / 1ps

package fud_pkg;

  localparam logic [1:0] KIND_KEY       = 2'd0;
  localparam logic [1:0] KIND_VALUE     = 2'd1;
  localparam logic [1:0] KIND_PAIR_END  = 2'd2;
  localparam logic [1:0] KIND_EMPTY_END = 2'd3;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam int MaxResults = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_payload;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       payload_done;
    logic       run_last;
  } out_beat_t;

endpackage

>>> rtl/core/form_urlencoded_decoder_core.sv
`timescale 1ns / 1ps

// Streaming form-urlencoded decoder. Each input beat is one payload byte; the
// beat with end_of_payload set closes the payload. The byte is decoded in the
// cycle it is taken and its zero to four results land in a four-entry result
// buffer, the first of them leaving from the next cycle on, one beat per cycle
// while the sink does not stall. The next byte is taken only when the buffer is
// empty or its last result leaves in that cycle: while the sink keeps up, a byte
// that gives at most one result is taken every cycle, and a byte that gives more
// (a flushed bad escape, a pair end at payload end) holds off the next byte
// while the buffer drains; every sink stall holds it off longer.
// Results carry key/value bytes, pair-end marks and an empty-payload-end mark,
// with run_last on the final result of each input byte.
module form_urlencoded_decoder_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fud_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fud_pkg::out_beat_t   out_data
);

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  // decoder state
  logic       in_value_part;
  logic [1:0] escape_pending;
  logic [7:0] held_high_char;
  logic       pair_nonempty;

  // result buffer, head at index 0
  fud_pkg::out_beat_t q [fud_pkg::MaxResults];
  logic [2:0]         cnt;

  fud_pkg::out_beat_t res [fud_pkg::MaxResults];
  logic [2:0]         n;
  logic               in_value_part_next;
  logic [1:0]         escape_pending_next;
  logic [7:0]         held_high_char_next;
  logic               pair_nonempty_next;
  logic               go;
  logic               hx;
  logic [7:0]         b;
  logic [1:0]         data_kind;
  logic [1:0]         end_kind;

  logic pop;
  logic accept;

  assign out_valid = (cnt != 3'd0);
  assign out_data  = q[0];
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((cnt == 3'd0) || ((cnt == 3'd1) && pop));
  assign accept    = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < fud_pkg::MaxResults; i++) begin
      res[i] = '0;
    end
    n                   = '0;
    b                   = in_data.in_byte;
    hx                  = is_hex(b);
    go                  = 1'b1;
    data_kind           = in_value_part ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
    in_value_part_next  = in_value_part;
    escape_pending_next = escape_pending;
    held_high_char_next = held_high_char;
    pair_nonempty_next  = pair_nonempty;

    // escape in progress
    if (escape_pending == fud_pkg::ESC_PCT) begin
      if (hx) begin
        held_high_char_next = b;
        escape_pending_next = fud_pkg::ESC_HEX;
        go                  = 1'b0;
      end else begin
        res[n[1:0]].out_byte = fud_pkg::CHAR_PERCENT;
        res[n[1:0]].kind     = data_kind;
        n                    = n + 3'd1;
        escape_pending_next  = fud_pkg::ESC_NONE;
      end
    end else if (escape_pending == fud_pkg::ESC_HEX) begin
      if (hx) begin
        res[n[1:0]].out_byte = {hex_nib(held_high_char), hex_nib(b)};
        res[n[1:0]].kind     = data_kind;
        n                    = n + 3'd1;
        escape_pending_next  = fud_pkg::ESC_NONE;
        held_high_char_next  = '0;
        go                   = 1'b0;
      end else begin
        res[n[1:0]].out_byte = fud_pkg::CHAR_PERCENT;
        res[n[1:0]].kind     = data_kind;
        n                    = n + 3'd1;
        res[n[1:0]].out_byte = held_high_char;
        res[n[1:0]].kind     = data_kind;
        n                    = n + 3'd1;
        escape_pending_next  = fud_pkg::ESC_NONE;
        held_high_char_next  = '0;
      end
    end

    // plain byte handling
    if (go) begin
      if (b == fud_pkg::CHAR_AMP) begin
        if (pair_nonempty) begin
          res[n[1:0]].kind = fud_pkg::KIND_PAIR_END;
          n                = n + 3'd1;
        end
        in_value_part_next  = 1'b0;
        escape_pending_next = fud_pkg::ESC_NONE;
        held_high_char_next = '0;
        pair_nonempty_next  = 1'b0;
      end else begin
        pair_nonempty_next = 1'b1;
        if (b == fud_pkg::CHAR_EQUALS && !in_value_part) begin
          in_value_part_next = 1'b1;
        end else if (b == fud_pkg::CHAR_PLUS) begin
          res[n[1:0]].out_byte = fud_pkg::CHAR_SPACE;
          res[n[1:0]].kind     = data_kind;
          n                    = n + 3'd1;
        end else if (b == fud_pkg::CHAR_PERCENT) begin
          escape_pending_next = fud_pkg::ESC_PCT;
        end else begin
          res[n[1:0]].out_byte = b;
          res[n[1:0]].kind     = data_kind;
          n                    = n + 3'd1;
        end
      end
    end

    // payload end: flush any open escape, then close
    if (in_data.end_of_payload) begin
      data_kind = in_value_part_next ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
      end_kind  = pair_nonempty_next ? fud_pkg::KIND_PAIR_END : fud_pkg::KIND_EMPTY_END;
      if (escape_pending_next == fud_pkg::ESC_PCT ||
          escape_pending_next == fud_pkg::ESC_HEX) begin
        res[n[1:0]].out_byte = fud_pkg::CHAR_PERCENT;
        res[n[1:0]].kind     = data_kind;
        n                    = n + 3'd1;
      end
      if (escape_pending_next == fud_pkg::ESC_HEX) begin
        res[n[1:0]].out_byte = held_high_char_next;
        res[n[1:0]].kind     = data_kind;
        n                    = n + 3'd1;
      end
      res[n[1:0]].kind         = end_kind;
      res[n[1:0]].payload_done = 1'b1;
      n                        = n + 3'd1;
      in_value_part_next  = 1'b0;
      escape_pending_next = fud_pkg::ESC_NONE;
      held_high_char_next = '0;
      pair_nonempty_next  = 1'b0;
    end else begin
      end_kind = fud_pkg::KIND_EMPTY_END;
    end

    if (n != 3'd0) begin
      res[2'(n - 3'd1)].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value_part  <= 1'b0;
      escape_pending <= fud_pkg::ESC_NONE;
      held_high_char <= '0;
      pair_nonempty  <= 1'b0;
      cnt            <= '0;
    end else if (accept) begin
      in_value_part  <= in_value_part_next;
      escape_pending <= escape_pending_next;
      held_high_char <= held_high_char_next;
      pair_nonempty  <= pair_nonempty_next;
      cnt            <= n;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < fud_pkg::MaxResults; i++) begin
        q[i] <= res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < fud_pkg::MaxResults - 1; i++) begin
        q[i] <= q[i + 1];
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("result buffer overfilled");

  a_run_last_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.run_last |-> cnt == 3'd1)
    else $error("run_last beat is not the last buffered result");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.payload_done |-> out_data.run_last)
    else $error("payload end not on the last result of its byte");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.end_of_payload |=>
      !in_value_part && escape_pending == fud_pkg::ESC_NONE && !pair_nonempty)
    else $error("state not cleared at payload end");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == fud_pkg::KIND_PAIR_END ||
                  out_data.kind == fud_pkg::KIND_EMPTY_END) |-> out_data.out_byte == 8'd0)
    else $error("marker beat carries a byte");

endmodule

>>> dv/tb_form_urlencoded_decoder_core.sv
`timescale 1ns / 1ps

module tb_form_urlencoded_decoder_core;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  fud_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fud_pkg::out_beat_t out_data;

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // decoder state as the stream is seen so far
  logic value_side = 1'b0;
  logic [1:0] esc_state = fud_pkg::ESC_NONE;
  logic [7:0] held_digit = '0;
  logic pair_has_bytes = 1'b0;

  fud_pkg::out_beat_t byte_results[$];
  fud_pkg::out_beat_t decoded_expect[$];
  logic [7:0] payload_bytes[$];

  always #2 clk = ~clk;

  form_urlencoded_decoder_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  function automatic int hex_nibble(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "a" && ch <= "f") return 10 + int'(ch - "a");
    if (ch >= "A" && ch <= "F") return 10 + int'(ch - "A");
    return -1;
  endfunction

  function automatic void add_byte(logic [7:0] ch);
    payload_bytes.insert(payload_bytes.size(), ch);
  endfunction

  function automatic void emit(logic [1:0] k, logic [7:0] ch, logic done);
    fud_pkg::out_beat_t r;
    r.out_byte = ch;
    r.kind = k;
    r.payload_done = done;
    r.run_last = 1'b0;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void emit_text(logic [7:0] ch);
    emit(value_side ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY, ch, 1'b0);
  endfunction

  function automatic void clear_decoder;
    value_side = 1'b0;
    esc_state = fud_pkg::ESC_NONE;
    held_digit = '0;
    pair_has_bytes = 1'b0;
  endfunction

  function automatic void predict_byte(logic [7:0] ch, logic last);
    int v;
    int h;
    logic [7:0] merged;
    logic absorbed;
    fud_pkg::out_beat_t r;
    byte_results.delete();
    v = hex_nibble(ch);
    absorbed = 1'b0;
    if (esc_state == fud_pkg::ESC_PCT) begin
      if (v >= 0) begin
        held_digit = ch;
        esc_state = fud_pkg::ESC_HEX;
        absorbed = 1'b1;
      end else begin
        emit_text(fud_pkg::CHAR_PERCENT);
        esc_state = fud_pkg::ESC_NONE;
      end
    end else if (esc_state == fud_pkg::ESC_HEX) begin
      if (v >= 0) begin
        h = hex_nibble(held_digit);
        if (h < 0) h = 0;
        merged = {h[3:0], v[3:0]};
        emit_text(merged);
        esc_state = fud_pkg::ESC_NONE;
        held_digit = '0;
        absorbed = 1'b1;
      end else begin
        emit_text(fud_pkg::CHAR_PERCENT);
        emit_text(held_digit);
        esc_state = fud_pkg::ESC_NONE;
        held_digit = '0;
      end
    end
    if (!absorbed) begin
      if (ch == fud_pkg::CHAR_AMP) begin
        if (pair_has_bytes) emit(fud_pkg::KIND_PAIR_END, 8'h00, 1'b0);
        clear_decoder();
      end else begin
        pair_has_bytes = 1'b1;
        if (ch == fud_pkg::CHAR_EQUALS && !value_side) value_side = 1'b1;
        else if (ch == fud_pkg::CHAR_PLUS) emit_text(fud_pkg::CHAR_SPACE);
        else if (ch == fud_pkg::CHAR_PERCENT) esc_state = fud_pkg::ESC_PCT;
        else emit_text(ch);
      end
    end
    if (last) begin
      if (esc_state == fud_pkg::ESC_PCT) begin
        emit_text(fud_pkg::CHAR_PERCENT);
      end else if (esc_state == fud_pkg::ESC_HEX) begin
        emit_text(fud_pkg::CHAR_PERCENT);
        emit_text(held_digit);
      end
      if (pair_has_bytes) emit(fud_pkg::KIND_PAIR_END, 8'h00, 1'b1);
      else emit(fud_pkg::KIND_EMPTY_END, 8'h00, 1'b1);
      clear_decoder();
    end
    for (int i = 0; i < byte_results.size(); i++) begin
      r = byte_results[i];
      r.run_last = (i == byte_results.size() - 1);
      decoded_expect.insert(decoded_expect.size(), r);
    end
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: ch, end_of_payload: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(ch, last);
  endtask

  task automatic send_payload;
    for (int i = 0; i < payload_bytes.size(); i++)
      send_byte(payload_bytes[i], i == payload_bytes.size() - 1);
    payload_bytes.delete();
  endtask

  task automatic test_pair_splitting;
    // leading '=', second '=' in value, empty pair, pair with no '='
    payload_bytes = '{"=", "b", "=", "&", "&", "c", "&", "d"};
    send_payload();
    // payload of only '&', which ends as an empty payload
    payload_bytes = '{fud_pkg::CHAR_AMP};
    send_payload();
  endtask

  task automatic test_escape_decoding;
    // good escape, plus, bad escapes, flush plus pair end plus empty end
    payload_bytes = '{"%", "4", "1", "+", "%", "z", "%", "4", "&"};
    send_payload();
    // mixed-case escape, byte extremes, escape cut at payload end
    payload_bytes = '{"%", "f", "F", 8'h00, 8'hFF, "%", "e"};
    send_payload();
  endtask

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return 8'("0" + v);
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] non_hex_char;
    logic [7:0] ch;
    case ($urandom_range(7))
      0: return fud_pkg::CHAR_AMP;
      1: return fud_pkg::CHAR_EQUALS;
      2: return fud_pkg::CHAR_PLUS;
      3: return fud_pkg::CHAR_PERCENT;
      default: begin
        do ch = 8'($urandom_range(255)); while (hex_nibble(ch) >= 0);
        return ch;
      end
    endcase
  endfunction

  function automatic void append_token;
    case ($urandom_range(15))
      0, 1, 2, 3, 4, 5, 6: begin
        case ($urandom_range(2))
          0: add_byte(8'("a" + $urandom_range(25)));
          1: add_byte(8'("A" + $urandom_range(25)));
          default: add_byte(8'("0" + $urandom_range(9)));
        endcase
      end
      7: add_byte(fud_pkg::CHAR_EQUALS);
      8: add_byte(fud_pkg::CHAR_AMP);
      9: add_byte(fud_pkg::CHAR_PLUS);
      10, 11: begin
        add_byte(fud_pkg::CHAR_PERCENT);
        add_byte(hex_char(int'($urandom_range(15)), 1'($urandom_range(1))));
        add_byte(hex_char(int'($urandom_range(15)), 1'($urandom_range(1))));
      end
      12: begin
        add_byte(fud_pkg::CHAR_PERCENT);
        add_byte(hex_char(int'($urandom_range(15)), 1'($urandom_range(1))));
        add_byte(non_hex_char());
      end
      13: begin
        add_byte(fud_pkg::CHAR_PERCENT);
        add_byte(non_hex_char());
      end
      default: add_byte(8'($urandom_range(255)));
    endcase
  endfunction

  task automatic test_random_payloads(input int n_bytes);
    int sent;
    int target;
    sent = 0;
    while (sent < n_bytes) begin
      target = $urandom_range(14, 1);
      while (payload_bytes.size() < target) append_token();
      // sometimes cut the payload short, often mid escape
      if (payload_bytes.size() > 1 && $urandom_range(5) == 0) void'(payload_bytes.pop_back());
      sent += payload_bytes.size();
      send_payload();
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("form_urlencoded_decoder_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    fud_pkg::out_beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_expect.size() == 0) begin
          $error("unexpected beat: out_byte %0h kind %0d", out_data.out_byte, out_data.kind);
          mismatch_count++;
        end else begin
          want = decoded_expect.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
            mismatch_count++;
          end
          if (out_data.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
            mismatch_count++;
          end
          if (out_data.payload_done !== want.payload_done) begin
            $error("payload_done: expected %0b, got %0b", want.payload_done,
                   out_data.payload_done);
            mismatch_count++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_data.run_last);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_gap_pct = 38;
    sink_stall_pct = 70;
    test_pair_splitting();
    test_escape_decoding();
    test_random_payloads(45);

    src_gap_pct = 70;
    sink_stall_pct = 38;
    test_random_payloads(45);

    src_gap_pct = 0;
    sink_stall_pct = 0;
    test_random_payloads(40);

    in_valid <= 1'b0;
    while (decoded_expect.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("form_urlencoded_decoder_core regression: pass");
    end else begin
      $display("form_urlencoded_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
